>>> hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg: shared types, widths and helpers for the k-transaction profit unit
// Holds field widths, the per-cell control word and the 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  localparam int PRICE_W  = 16;   // price field
  localparam int DIFF_W   = 17;   // signed day-to-day difference
  localparam int PROFIT_W = 32;   // signed stage profit
  localparam int WIDE_W   = 33;   // profit plus difference before saturation
  localparam int CFG_W    = 5;    // max_transactions register
  localparam int RESULT_W = 31;   // max_profit field
  localparam int TDATA_OUT_W = 32;

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(2);

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -33'sh0_8000_0000;

  // Control word broadcast to every cell
  typedef struct packed {
    logic upd;  // apply one day's difference
    logic clr;  // end of sequence: drop the stage profit
  } cell_ctrl_t;

  // Clamp a 33-bit signed value to the 32-bit signed range
  function automatic logic signed [PROFIT_W-1:0] sat_profit(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [PROFIT_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < WIDE_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[PROFIT_W-1:0];
    end
    return r;
  endfunction

  // Sign-extend a profit to the wide width
  function automatic logic signed [WIDE_W-1:0] widen(input logic signed [PROFIT_W-1:0] v);
    return {v[PROFIT_W-1], v};
  endfunction

  // Sign-extend a difference to the wide width
  function automatic logic signed [WIDE_W-1:0] widen_diff(input logic signed [DIFF_W-1:0] v);
    return {{(WIDE_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kmp_cell.sv
// ----------------------------------------------------------------------------
// kmp_cell: one stage of the profit chain
// Holds one stage profit, updates it from its left neighbor's old value and
// the day's difference, and passes a running maximum to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_cell
  import kmp_pkg::*;
#(
  parameter bit HOLDS_STOCK = 1'b1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cell_ctrl_t                 ctrl_i,
  input  wire logic signed [DIFF_W-1:0]   diff_i,
  input  wire logic signed [PROFIT_W-1:0] prev_i,  // left neighbor's stage profit
  input  wire logic                       incl_i,  // stage counts toward the maximum
  input  wire logic signed [PROFIT_W-1:0] max_i,   // running maximum from the left
  output logic signed [PROFIT_W-1:0]      val_o,
  output logic signed [PROFIT_W-1:0]      max_o
);

  logic signed [PROFIT_W-1:0] val_q, val_d;
  logic signed [PROFIT_W-1:0] max_q, max_d;
  logic signed [WIDE_W-1:0]   keep, move, best;

  // Pick between keeping the position and moving from the left stage
  always_comb begin
    if (HOLDS_STOCK) begin
      keep = widen(val_q) + widen_diff(diff_i);
      move = widen(prev_i);
    end else begin
      keep = widen(val_q);
      move = widen(prev_i) + widen_diff(diff_i);
    end
    best = (keep > move) ? keep : move;

    val_d = val_q;
    if (ctrl_i.clr) begin
      val_d = '0;
    end else if (ctrl_i.upd) begin
      val_d = sat_profit(best);
    end
  end

  // Fold this stage into the running maximum
  always_comb begin
    max_d = max_i;
    if (incl_i && (val_q > max_i)) begin
      max_d = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
  end

  assign val_o = val_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

>>> hw/rtl/k_transaction_max_profit_unit.sv
// ----------------------------------------------------------------------------
// k_transaction_max_profit_unit: best profit with at most k trades
// Streams daily prices through a chain of stage cells and, on the last
// word of a sequence, reports the best profit for the configured k.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[15:0] price, tlast last
//  m_axis    out  m_axis_tvalid/tready       tdata[30:0] max_profit
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i max_transactions
//
//  One price word is taken per cycle; every cell updates in the same cycle.
//  After a last word the unit enters a reduce pass in which the running
//  maximum ripples down the cell chain; s_axis_tready is low meanwhile.
//  If the previous result has not been taken then, the unit waits for it.
//  Reset sets max_transactions to 2 and clears all sequence state at once.
//  The result register lets a new sequence start while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module k_transaction_max_profit_unit
  import kmp_pkg::*;
#(
  parameter int MAX_TRANS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [PRICE_W-1:0]     s_axis_tdata,   // [15:0] price
  input  wire logic                   s_axis_tlast,   // last day of the sequence
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // [30:0] max_profit, [31] zero
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_W-1:0]       cfg_data_i      // [4:0] max_transactions
);

  localparam int STAGES  = 2 * MAX_TRANS + 1;
  localparam int DAY_CAP = 2 * MAX_TRANS + 2;
  localparam int DW      = $clog2(DAY_CAP + 1);
  localparam int KW      = ($clog2(MAX_TRANS + 1) > CFG_W) ? $clog2(MAX_TRANS + 1) : CFG_W;
  localparam int CW      = (DW > KW) ? DW : KW;
  localparam int NW      = $clog2(STAGES + 1);

  typedef enum logic {ST_RUN, ST_REDUCE} state_e;

  state_e                    state_q;
  logic [CFG_W-1:0]          k_q;
  logic [PRICE_W-1:0]        prev_price_q;
  logic [DW-1:0]             days_q, days_next;
  logic signed [PROFIT_W-1:0] rsum_q, rsum_next;
  logic                      too_few_q, use_sum_q;
  logic [NW-1:0]             cnt_q;
  logic                      out_valid_q;
  logic [RESULT_W-1:0]       out_data_q;

  logic                      in_acc, reduce_done, out_free, finish;
  logic signed [DIFF_W-1:0]  diff;
  logic [KW-1:0]             k_ext, kc;
  logic [KW:0]               k_twice;
  logic signed [PROFIT_W-1:0] result;
  cell_ctrl_t                ctrl;

  logic signed [PROFIT_W-1:0] val [STAGES];
  logic signed [PROFIT_W-1:0] mx  [STAGES];
  logic [STAGES-1:0]          incl;

  // Handshakes
  assign s_axis_tready = (state_q == ST_RUN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign reduce_done   = (state_q == ST_REDUCE) && (cnt_q == NW'(STAGES));
  assign finish        = reduce_done && out_free;

  // Day difference, day count and rising sum
  assign diff = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, prev_price_q});
  assign days_next = (days_q < DW'(DAY_CAP)) ? days_q + DW'(1) : days_q;
  always_comb begin
    rsum_next = rsum_q;
    if (diff > 0) begin
      rsum_next = sat_profit(widen(rsum_q) + widen_diff(diff));
    end
  end

  // Clamp k to MAX_TRANS, the largest k the cell chain supports
  assign k_ext   = KW'(k_q);
  assign kc      = (k_ext > KW'(MAX_TRANS)) ? KW'(MAX_TRANS) : k_ext;
  assign k_twice = {kc, 1'b0};

  assign ctrl.upd = in_acc && (days_q != '0);
  assign ctrl.clr = finish;

  // Stage zero never trades
  assign val[0]  = '0;
  assign mx[0]   = '0;
  assign incl[0] = 1'b1;

  for (genvar j = 1; j < STAGES; j++) begin : g_cell
    assign incl[j] = ((KW + 1)'(j) <= k_twice);
    kmp_cell #(
      .HOLDS_STOCK(j % 2 == 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .diff_i (diff),
      .prev_i (val[j-1]),
      .incl_i (incl[j]),
      .max_i  (mx[j-1]),
      .val_o  (val[j]),
      .max_o  (mx[j])
    );
  end

  // Select the reported profit
  always_comb begin
    if (too_few_q) begin
      result = '0;
    end else if (use_sum_q) begin
      result = rsum_q;
    end else begin
      result = mx[STAGES-1];
    end
  end

  // Sequence control, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      k_q          <= K_RESET;
      prev_price_q <= '0;
      days_q       <= '0;
      rsum_q       <= '0;
      too_few_q    <= 1'b0;
      use_sum_q    <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        k_q <= cfg_data_i;
      end
      // Load a new result word or drop the one just taken
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (in_acc) begin
            prev_price_q <= s_axis_tdata;
            days_q       <= days_next;
            if (days_q != '0) begin
              rsum_q <= rsum_next;
            end
            if (s_axis_tlast) begin
              too_few_q <= (days_q == '0);
              use_sum_q <= CW'(days_next >> 1) < CW'(kc);
              cnt_q     <= '0;
              state_q   <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (!reduce_done) begin
            cnt_q <= cnt_q + NW'(1);
          end
          if (finish) begin
            prev_price_q <= '0;
            days_q       <= '0;
            rsum_q       <= '0;
            state_q      <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= result[RESULT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // Checks
  a_last_starts_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (state_q == ST_REDUCE && cnt_q == '0))
    else $error("last word did not start the max pass");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(STAGES))
    else $error("max pass counter overran the chain length");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (days_q == '0 && rsum_q == '0 && m_axis_tvalid))
    else $error("sequence state not cleared at result load");

  a_result_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> !result[PROFIT_W-1])
    else $error("negative profit reported");

endmodule

`default_nettype wire

>>> verif/tb_k_transaction_max_profit_unit.sv
// ----------------------------------------------------------------------------
// tb_k_transaction_max_profit_unit: stream test for the k-trade profit unit
// Drives price sequences with random gaps, stalls the result side at random,
// predicts every sequence's best profit in a local model and checks each
// result word in order. Covers the reset k, random k settings including ones
// above MAX_TRANS, and day counts on both sides of the 2k boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_k_transaction_max_profit_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  localparam int MAX_TRANS    = 16;
  localparam int STAGES       = 2 * MAX_TRANS + 1;
  localparam int DAY_CAP      = 2 * MAX_TRANS + 2;
  localparam int DRAIN_CYCLES = 2 * MAX_TRANS + 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 10;
  localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};

  typedef enum int {PAT_UNIFORM, PAT_WALK, PAT_SWING, PAT_FLAT} price_pattern_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [PRICE_W-1:0]     s_axis_tdata;   // [15:0] price
  logic                   s_axis_tlast;   // last day of the sequence
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [30:0] max_profit, [31] zero
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;     // [4:0] max_transactions

  // Local copy of the sequence state and the k register
  logic signed [PROFIT_W-1:0] stage_gain [STAGES];
  logic [PRICE_W-1:0]         prior_price;
  int unsigned                day_count;
  logic signed [PROFIT_W-1:0] upswing_total;
  logic [CFG_W-1:0]           k_setting;

  logic [RESULT_W-1:0] profit_due_q[$];
  int  fail_count;
  int  items_sent;
  bit  steady;

  k_transaction_max_profit_unit #(
    .MAX_TRANS(MAX_TRANS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  // Clamp to the 32-bit signed range
  function automatic logic signed [PROFIT_W-1:0] clamp_profit(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(33'sh0_8000_0000)) return -32'sh8000_0000;
    return v[PROFIT_W-1:0];
  endfunction

  function automatic void clear_sequence();
    foreach (stage_gain[j]) stage_gain[j] = '0;
    prior_price   = '0;
    day_count     = 0;
    upswing_total = '0;
  endfunction

  // Advance the local state by one day; queue the best profit on the last day
  function automatic void predict_day(input logic [PRICE_W-1:0] price, input logic last);
    logic signed [PROFIT_W-1:0] next_gain [STAGES];
    int unsigned k;
    longint now_p, was_p, diff, keep, move, best;
    k = k_setting;
    if (k > MAX_TRANS) k = MAX_TRANS;
    if (day_count >= 1) begin
      now_p = price;
      was_p = prior_price;
      diff  = now_p - was_p;
      next_gain[0] = '0;
      for (int j = 1; j < STAGES; j++) begin
        if (j % 2 == 1) begin
          keep = longint'(stage_gain[j]) + diff;
          move = longint'(stage_gain[j-1]);
        end else begin
          keep = longint'(stage_gain[j]);
          move = longint'(stage_gain[j-1]) + diff;
        end
        next_gain[j] = clamp_profit(keep > move ? keep : move);
      end
      stage_gain = next_gain;
      if (diff > 0) upswing_total = clamp_profit(longint'(upswing_total) + diff);
    end
    prior_price = price;
    if (day_count < DAY_CAP) day_count++;
    if (!last) return;
    best = 0;
    if (day_count >= 2) begin
      if (day_count / 2 < k) begin
        best = upswing_total;
      end else begin
        for (int j = 0; j <= 2 * k && j < STAGES; j++) begin
          if (longint'(stage_gain[j]) > best) best = stage_gain[j];
        end
      end
      if (best < 0) best = 0;
    end
    profit_due_q.push_back(best[RESULT_W-1:0]);
    clear_sequence();
  endfunction

  function automatic void log_failure(input string what, input logic [TDATA_OUT_W-1:0] want,
                                      input logic [TDATA_OUT_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Send one price word; valid stays high so back-to-back words need no gap
  task automatic send_price(input logic [PRICE_W-1:0] price, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_day(price, last);
    items_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the cell chain drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (profit_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    k_setting = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_run(input int len);
    price_pattern_e pattern;
    int p;
    pattern = price_pattern_e'($urandom_range(0, 3));
    p = $urandom_range(0, 65535);
    for (int j = 0; j < len; j++) begin
      case (pattern)
        PAT_UNIFORM: begin
          p = $urandom_range(0, 65535);
        end
        PAT_WALK: begin
          p = p + int'($urandom_range(0, 400)) - 200;
        end
        PAT_SWING: begin
          p = $urandom_range(0, 1) ? 65535 : 0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) p = p + int'($urandom_range(0, 4)) - 2;
        end
      endcase
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      send_price(p[PRICE_W-1:0], j == len - 1);
    end
  endtask

  // Reset value of k is 2: one run below the boundary, one at it
  task automatic test_default_k();
    send_price(16'd10, 1'b0);
    send_price(16'd30, 1'b0);
    send_price(16'd20, 1'b1);
    send_price(16'd100, 1'b0);
    send_price(16'd50, 1'b0);
    send_price(16'd300, 1'b0);
    send_price(16'd200, 1'b1);
    settle();
  endtask

  // One day gives zero; two days up and two days down
  task automatic test_short_sequences();
    send_price(16'd4242, 1'b1);
    send_price(16'd100, 1'b0);
    send_price(16'd900, 1'b1);
    send_price(16'd900, 1'b0);
    send_price(16'd100, 1'b1);
    settle();
  endtask

  task automatic test_price_extremes();
    write_k(5'd1);
    send_price('0, 1'b0);
    send_price(PRICE_TOP, 1'b0);
    send_price('0, 1'b0);
    send_price(PRICE_TOP, 1'b1);
    settle();
  endtask

  // With k of zero every sequence reports zero
  task automatic test_zero_k();
    write_k(5'd0);
    send_price(16'd5, 1'b0);
    send_price(16'd9, 1'b0);
    send_price(16'd2, 1'b0);
    send_price(16'd14, 1'b1);
    send_price(16'd77, 1'b1);
    settle();
  endtask

  // k beyond MAX_TRANS is held at the largest supported value
  task automatic test_k_above_limit();
    write_k(5'd31);
    send_price(16'd7, 1'b0);
    send_price(16'd3, 1'b0);
    send_price(16'd11, 1'b1);
    settle();
  endtask

  // Random k per phase, a few sequences each, mostly short ones
  task automatic test_random_phases();
    int runs, len, pick;
    while (items_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) write_k(5'($urandom_range(17, 31)));
      else write_k(5'($urandom_range(0, 16)));
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(1, 8);
        else if (pick < 9) len = $urandom_range(9, 34);
        else len = $urandom_range(35, 50);
        send_random_run(len);
      end
      settle();
    end
    steady = 1'b0;
  endtask

  // Stimulus and final verdict
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    fail_count = 0;
    items_sent = 0;
    steady     = 1'b0;
    k_setting  = K_RESET;
    clear_sequence();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_k();
    test_short_sequences();
    test_price_extremes();
    test_zero_k();
    test_k_above_limit();
    test_random_phases();
    if (fail_count == 0 && profit_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before each word
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each accepted result word with the oldest pending profit
  always @(posedge clk_i) begin
    logic [TDATA_OUT_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (profit_due_q.size() == 0) begin
        log_failure("result word with no sequence pending", 'x, m_axis_tdata);
      end else begin
        want = TDATA_OUT_W'(profit_due_q.pop_front());
        if (m_axis_tdata !== want) log_failure("max_profit", want, m_axis_tdata);
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
